@@ design/highpass_biquad_cascade_unit_macros.svh @@
// assertion macros for the high-pass cascade port checker
`ifndef HIGHPASS_BIQUAD_CASCADE_UNIT_MACROS_SVH
`define HIGHPASS_BIQUAD_CASCADE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define HBC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbc assertion failed");

// next-cycle implication, checked outside reset
`define HBC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbc assertion failed");

`endif

@@ design/hbc_pkg.sv @@
// shared types, constants and rounding functions of the high-pass cascade
package hbc_pkg;

  localparam int MAX_SECTIONS_DEF = 7;

  // register map and apb port
  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 6;
  localparam int BYTE_SH    = 3;
  localparam int REG_IDX_W  = ADDR_W - BYTE_SH;
  localparam int CNT_W      = 3;
  localparam int COEF_W     = 18;
  localparam int COEF_REG_W = 3 * COEF_W;

  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_SECTIONS = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_COEF_BASE       = REG_IDX_W'(1);

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int STATE_W  = 32;
  localparam int DIFF_W   = STATE_W + 2;
  localparam int PROD_W   = COEF_W + DIFF_W;
  localparam int ACC_W    = PROD_W;
  localparam int HALF_LSB = 1 << (FRAC_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A1,
    ST_MUL_A2,
    ST_SUB,
    ST_NORM_W0,
    ST_DIFF,
    ST_MUL_G,
    ST_NORM_Y,
    ST_FINISH
  } hbc_state_t;

  typedef struct packed {
    logic load;
    logic mul_a1;
    logic mul_a2;
    logic sub;
    logic norm_w0;
    logic diff;
    logic mul_g;
    logic norm_y;
    logic out_load;
  } hbc_ctrl_t;

  // round half up to q16.16 and saturate to 32 bits
  function automatic logic signed [STATE_W-1:0] rnd_sat32(
    input logic signed [ACC_W:0] v
  );
    logic [ACC_W:0]                r;
    logic [ACC_W-FRAC_W:0]         q;
    logic [ACC_W-FRAC_W-STATE_W+1:0] hi;
    r  = v + (ACC_W+1)'(HALF_LSB);
    q  = r[ACC_W:FRAC_W];
    hi = q[ACC_W-FRAC_W:STATE_W-1];
    if (hi == '0 || hi == '1) begin
      return q[STATE_W-1:0];
    end
    return {q[ACC_W-FRAC_W], {(STATE_W-1){~q[ACC_W-FRAC_W]}}};
  endfunction

  // round half up to integer and saturate to 16 bits
  function automatic logic signed [SAMPLE_W-1:0] rnd_sat16(
    input logic signed [STATE_W-1:0] v
  );
    logic [STATE_W:0]                  r;
    logic [STATE_W-FRAC_W:0]           q;
    logic [STATE_W-FRAC_W-SAMPLE_W+1:0] hi;
    r  = (STATE_W+1)'(v) + (STATE_W+1)'(HALF_LSB);
    q  = r[STATE_W:FRAC_W];
    hi = q[STATE_W-FRAC_W:SAMPLE_W-1];
    if (hi == '0 || hi == '1) begin
      return q[SAMPLE_W-1:0];
    end
    return {q[STATE_W-FRAC_W], {(SAMPLE_W-1){~q[STATE_W-FRAC_W]}}};
  endfunction

endpackage

@@ design/hbc_mul.sv @@
// shared signed multiplier with registered product
module hbc_mul
  import hbc_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [COEF_W-1:0] a,
  input  logic signed [DIFF_W-1:0] b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

@@ design/hbc_cfg.sv @@
// apb register file: section count and packed per-section coefficients
module hbc_cfg
  import hbc_pkg::*;
#(
  parameter  int MAX_SECTIONS = MAX_SECTIONS_DEF,
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  input  logic [SEC_W-1:0]      sec_rd,
  output logic [CNT_W-1:0]      active_sections,
  output logic [COEF_REG_W-1:0] coef_rd
);

  logic [COEF_REG_W-1:0] coef_regs [MAX_SECTIONS];
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [REG_IDX_W-1:0]  coef_idx;
  logic                  coef_hit;
  logic                  wr_en;
  logic [DATA_W-1:0]     rd_data;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[BYTE_SH +: REG_IDX_W];
  assign coef_idx = reg_idx - REG_COEF_BASE;
  assign coef_hit = (reg_idx != REG_ACTIVE_SECTIONS) &&
                    (coef_idx < REG_IDX_W'(MAX_SECTIONS));
  assign wr_en    = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sections <= CNT_W'(1);
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        coef_regs[i] <= '0;
      end
    end else if (wr_en) begin
      if (reg_idx == REG_ACTIVE_SECTIONS) begin
        active_sections <= pwdata[CNT_W-1:0];
      end else if (coef_hit) begin
        coef_regs[coef_idx[SEC_W-1:0]] <= pwdata[COEF_REG_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx == REG_ACTIVE_SECTIONS) begin
      rd_data = DATA_W'(active_sections);
    end else if (coef_hit) begin
      rd_data = DATA_W'(coef_regs[coef_idx[SEC_W-1:0]]);
    end else begin
      rd_data = '0;
    end
  end

  // read data captured in the setup phase, valid in the access phase
  always_ff @(posedge clk) begin
    if (psel && !penable) begin
      prdata <= rd_data;
    end
    coef_rd <= coef_regs[sec_rd];
  end

endmodule

@@ design/hbc_ctrl.sv @@
// section sequencer: handshakes, section counter and step strobes
module hbc_ctrl
  import hbc_pkg::*;
#(
  parameter  int MAX_SECTIONS = MAX_SECTIONS_DEF,
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic [CNT_W-1:0] active_sections,
  output hbc_ctrl_t        ctrl,
  output logic [SEC_W-1:0] sec,
  output logic [SEC_W-1:0] sec_next
);

  hbc_state_t       state;
  hbc_state_t       state_next;
  logic             out_valid_next;
  logic [CNT_W-1:0] cnt_eff;
  logic             last_sec;

  // zero means one section, anything above the build limit is clamped
  always_comb begin
    if (active_sections == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (active_sections > CNT_W'(MAX_SECTIONS)) begin
      cnt_eff = CNT_W'(MAX_SECTIONS);
    end else begin
      cnt_eff = active_sections;
    end
  end

  assign last_sec = (CNT_W'(sec) == cnt_eff - CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = ST_MUL_A1;
      ST_MUL_A1:  state_next = ST_MUL_A2;
      ST_MUL_A2:  state_next = ST_SUB;
      ST_SUB:     state_next = ST_NORM_W0;
      ST_NORM_W0: state_next = ST_DIFF;
      ST_DIFF:    state_next = ST_MUL_G;
      ST_MUL_G:   state_next = ST_NORM_Y;
      ST_NORM_Y:  state_next = last_sec ? ST_FINISH : ST_MUL_A1;
      ST_FINISH:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    in_ready      = (state == ST_IDLE);
    ctrl.load     = in_ready && in_valid;
    ctrl.mul_a1   = (state == ST_MUL_A1);
    ctrl.mul_a2   = (state == ST_MUL_A2);
    ctrl.sub      = (state == ST_SUB);
    ctrl.norm_w0  = (state == ST_NORM_W0);
    ctrl.diff     = (state == ST_DIFF);
    ctrl.mul_g    = (state == ST_MUL_G);
    ctrl.norm_y   = (state == ST_NORM_Y);
    ctrl.out_load = (state == ST_FINISH) && (!out_valid || out_ready);
  end

  always_comb begin
    if (ctrl.load) begin
      sec_next = '0;
    end else if (ctrl.norm_y && !last_sec) begin
      sec_next = sec + SEC_W'(1);
    end else begin
      sec_next = sec;
    end
  end

  always_comb begin
    if (ctrl.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sec       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sec       <= sec_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

@@ design/hbc_datapath.sv @@
// section datapath: delay lines, accumulator, rounding and output register
module hbc_datapath
  import hbc_pkg::*;
#(
  parameter  int MAX_SECTIONS = MAX_SECTIONS_DEF,
  localparam int SEC_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hbc_ctrl_t                  ctrl,
  input  logic [SEC_W-1:0]           sec,
  input  logic [COEF_REG_W-1:0]      coef,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       clear_state,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  logic signed [STATE_W-1:0] delay_one [MAX_SECTIONS];
  logic signed [STATE_W-1:0] delay_two [MAX_SECTIONS];

  logic signed [STATE_W-1:0] x;
  logic signed [STATE_W-1:0] w0;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DIFF_W-1:0]  e;
  logic signed [DIFF_W-1:0]  d;
  logic signed [PROD_W-1:0]  prod;

  logic signed [STATE_W-1:0] w1;
  logic signed [STATE_W-1:0] w2;
  logic signed [COEF_W-1:0]  a1;
  logic signed [COEF_W-1:0]  a2;
  logic signed [COEF_W-1:0]  g;
  logic signed [COEF_W-1:0]  mul_a;
  logic signed [DIFF_W-1:0]  mul_b;
  logic                      mul_en;

  assign w1 = delay_one[sec];
  assign w2 = delay_two[sec];
  assign a1 = coef[3*COEF_W-1:2*COEF_W];
  assign a2 = coef[2*COEF_W-1:COEF_W];
  assign g  = coef[COEF_W-1:0];

  always_comb begin
    mul_en = ctrl.mul_a1 || ctrl.mul_a2 || ctrl.mul_g;
    priority if (ctrl.mul_a1) begin
      mul_a = a1;
      mul_b = DIFF_W'(w1);
    end else if (ctrl.mul_a2) begin
      mul_a = a2;
      mul_b = DIFF_W'(w2);
    end else begin
      mul_a = g;
      mul_b = d;
    end
  end

  hbc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (ctrl.load && clear_state) begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (ctrl.diff) begin
      delay_two[sec] <= w1;
      delay_one[sec] <= w0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= {sample_in, {FRAC_W{1'b0}}};
    end else if (ctrl.norm_y) begin
      x <= rnd_sat32((ACC_W+1)'(prod));
    end
    if (ctrl.mul_a1) begin
      acc <= ACC_W'(x) <<< FRAC_W;
      e   <= DIFF_W'(w2) - (DIFF_W'(w1) <<< 1);
    end else if (ctrl.mul_a2 || ctrl.sub) begin
      acc <= acc - prod;
    end
    if (ctrl.norm_w0) begin
      w0 <= rnd_sat32((ACC_W+1)'(acc));
    end
    if (ctrl.diff) begin
      d <= DIFF_W'(w0) + e;
    end
    if (ctrl.out_load) begin
      sample_out <= rnd_sat16(x);
    end
  end

endmodule

@@ design/highpass_biquad_cascade_unit.sv @@
// top level of the butterworth high-pass biquad cascade
// each input transaction runs through all N active sections (1..7) before the next is taken,
//   the single shared multiplier stepping through a1*w1, a2*w2 and g*d for each section in turn
// reset: synchronous rst zeroes all delay states, sets active_sections to 1 and
//   all coefficients to 0; no clearing pass, the block is ready right after reset
module highpass_biquad_cascade_unit
  import hbc_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // sample input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       clear_state,
  // filtered output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  // configuration port, register i at byte address 8*i
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output logic [DATA_W-1:0]          prdata,
  output logic                       pready
);

  localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  hbc_ctrl_t             ctrl;
  logic [SEC_W-1:0]      sec;
  logic [SEC_W-1:0]      sec_next;
  logic [CNT_W-1:0]      active_sections;
  logic [COEF_REG_W-1:0] coef;

  // register file; coefficient read is registered and addressed by the
  // sequencer's next section so the word is ready when the section starts
  hbc_cfg #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_cfg (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .sec_rd          (sec_next),
    .active_sections (active_sections),
    .coef_rd         (coef)
  );

  // sequencer: per section the steps are
  //   a1*w1, a2*w2 (acc gets x << 16 minus first product), subtract second product,
  //   round/saturate to w0, form w0 - 2*w1 + w2 and shift the delay pair,
  //   g*d, round/saturate to the section output
  // a finished sample waits in the output register; a new transaction is
  // taken while it waits, and the next result holds until the slot drains
  hbc_ctrl #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .active_sections (active_sections),
    .ctrl            (ctrl),
    .sec             (sec),
    .sec_next        (sec_next)
  );

  // delay lines, accumulator and the shared multiplier
  hbc_datapath #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .sec         (sec),
    .coef        (coef),
    .sample_in   (sample_in),
    .clear_state (clear_state),
    .sample_out  (sample_out)
  );

endmodule

@@ design/hbc_checker.sv @@
// port-level checker for the high-pass cascade, bound to the top level
`include "highpass_biquad_cascade_unit_macros.svh"

module hbc_port_checker
  import hbc_pkg::*;
(
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample_out,
  input logic                       pready
);

  // an accepted transaction keeps the block busy, so in_ready drops
  `HBC_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // with nothing pending and the block idle, no result appears next cycle
  `HBC_ASSERT_NXT(a_no_instant_result, clk, rst, in_ready && !out_valid, !out_valid)

  // a stalled result stays put
  `HBC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(sample_out))

  // the register port never inserts wait states
  `HBC_ASSERT_IMP(a_pready_high, clk, rst, 1'b1, pready)

endmodule

bind highpass_biquad_cascade_unit hbc_port_checker u_hbc_checker (.*);

@@ tb/hbc_checker.sv @@
// channel monitor, cascade predictor and result comparison for the high-pass cascade
module hbc_checker
  import hbc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       clear_state,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [SAMPLE_W-1:0] sample_out,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ADDR_W-1:0]          paddr,
  input  logic [DATA_W-1:0]          pwdata,
  output int                         pending,
  output int                         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  logic [CNT_W-1:0]             sections;
  logic [COEF_REG_W-1:0]        coef [MAX_SECTIONS_DEF];
  logic signed [STATE_W-1:0]    w_one [MAX_SECTIONS_DEF];
  logic signed [STATE_W-1:0]    w_two [MAX_SECTIONS_DEF];
  logic signed [SAMPLE_W-1:0]   filtered_q [$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // round half up from q.32 to q16.16, saturate to 32 bits
  function automatic longint round_q16(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > Q_MAX) r = Q_MAX;
    if (r < Q_MIN) r = Q_MIN;
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input logic                       clr
  );
    logic signed [COEF_W-1:0] a1_f, a2_f, g_f;
    longint x, w1, w2, d, r;
    logic signed [STATE_W-1:0] w0;
    int n;
    n = (sections == 0) ? 1 : int'(sections);
    if (n > MAX_SECTIONS_DEF) n = MAX_SECTIONS_DEF;
    if (clr) begin
      for (int k = 0; k < MAX_SECTIONS_DEF; k++) begin
        w_one[k] = '0;
        w_two[k] = '0;
      end
    end
    x = longint'(s) * 65536;
    for (int k = 0; k < n; k++) begin
      a1_f = coef[k][3*COEF_W-1:2*COEF_W];
      a2_f = coef[k][2*COEF_W-1:COEF_W];
      g_f  = coef[k][COEF_W-1:0];
      w1   = w_one[k];
      w2   = w_two[k];
      w0   = STATE_W'(round_q16(x * 65536 - longint'(a1_f) * w1 - longint'(a2_f) * w2));
      d    = longint'(w0) - 2 * w1 + w2;
      x    = round_q16(d * longint'(g_f));
      w_two[k] = w_one[k];
      w_one[k] = w0;
    end
    r = (x + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return SAMPLE_W'(r);
  endfunction

  always @(posedge clk) begin : monitor
    logic [REG_IDX_W-1:0]       idx;
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      sections = CNT_W'(1);
      for (int k = 0; k < MAX_SECTIONS_DEF; k++) begin
        coef[k]  = '0;
        w_one[k] = '0;
        w_two[k] = '0;
      end
      filtered_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[ADDR_W-1:BYTE_SH];
        if (idx == REG_ACTIVE_SECTIONS) begin
          sections = pwdata[CNT_W-1:0];
        end else begin
          coef[idx - REG_COEF_BASE] = pwdata[COEF_REG_W-1:0];
        end
      end
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected output transaction, actual %0d", $time, sample_out);
        end else begin
          want = filtered_q.pop_front();
          if (sample_out !== want) begin
            fail_count++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, sample_out);
          end
        end
      end
      if (in_valid && in_ready) begin
        filtered_q.push_back(filter_sample(sample_in, clear_state));
      end
    end
    pending = filtered_q.size();
  end

endmodule

@@ tb/tb.sv @@
// stimulus, handshake pacing and verdict for the high-pass biquad cascade
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hbc_pkg::*;

  // drain wait scaled by the section limit, long enough for one full pass
  localparam int DRAIN_CYCLES   = 7 * MAX_SECTIONS_DEF + 10;
  // slowest quiet stretch is a full seven-section item behind the longest receiver
  // stall or sender gap; take it many times over
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RAND_PHASES    = 10;
  localparam int PHASE_ITEMS    = 103;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       clear_state;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [ADDR_W-1:0]          paddr;
  logic [DATA_W-1:0]          pwdata;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;
  int                         pending;
  int                         fail_count;

  highpass_biquad_cascade_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .clear_state (clear_state),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // predictor and scoreboard live in the checker, fed from the same wires
  hbc_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample_in   (sample_in),
    .clear_state (clear_state),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog: any accepted transaction on any port restarts the count
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: switches between always ready, coin-flip ready and long stalls
  int rx_mode    = 0;
  int rx_stall   = 0;
  int rx_cycles  = 0;
  always @(negedge clk) begin
    rx_cycles++;
    if (rx_cycles % 300 == 0) begin
      rx_mode = $urandom_range(0, 2);
    end
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: begin
          out_ready <= 1'b1;
        end
        1: begin
          out_ready <= 1'($urandom);
        end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_stall = $urandom_range(5, 40);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // apb write: setup, access, then idle, so psel never toggles twice in a step
  task automatic reg_write(input int idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << BYTE_SH);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // one input transaction; valid stays high on return so bursts run back to back
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic clr);
    in_valid    <= 1'b1;
    sample_in   <= s;
    clear_state <= clr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and hold until every predicted sample has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // roughly butterworth-shaped stable section with unity gain near nyquist
  function automatic logic [COEF_REG_W-1:0] stable_section();
    int a1_v, a2_v, g_v;
    a2_v = $urandom_range(13107, 64225);
    a1_v = -int'($urandom_range(0, 65536 + a2_v - 512));
    g_v  = (65536 - a1_v + a2_v) / 4;
    return {COEF_W'(a1_v), COEF_W'(a2_v), COEF_W'(g_v)};
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] s;
    logic                       clr;
    int                         burst_left;
    int                         gap;
    bit                         no_gaps;
    rst         = 1'b1;
    in_valid    = 1'b0;
    sample_in   = '0;
    clear_state = 1'b0;
    out_ready   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero sections count as one; section 0 is a bare (1,-2,1) numerator
    reg_write(REG_ACTIVE_SECTIONS, '0);
    reg_write(REG_COEF_BASE, {COEF_W'(0), COEF_W'(0), COEF_W'(65536)});
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh0000, 1'b0);
    wait_drained();

    // all seven sections at the coefficient extremes, drives w0 and y into saturation
    reg_write(REG_ACTIVE_SECTIONS, 64'd7);
    for (int r = 0; r < MAX_SECTIONS_DEF; r++) begin
      reg_write(REG_COEF_BASE + r, {18'h1ffff, 18'h20000, 18'h1ffff});
    end
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh0064, 1'b0);
    wait_drained();

    // junk above the register width must be masked off: count reads back as 5
    reg_write(REG_ACTIVE_SECTIONS, 64'hffff_ffff_ffff_fffd);
    for (int r = 0; r < MAX_SECTIONS_DEF; r++) begin
      reg_write(REG_COEF_BASE + r, {10'h3ff, stable_section()});
    end
    send_sample(16'sh4000, 1'b1);
    send_sample(16'shc000, 1'b0);
    send_sample(16'sh1234, 1'b0);
    wait_drained();

    // shrink to two sections; sections 2..4 must keep their history
    reg_write(REG_ACTIVE_SECTIONS, 64'd2);
    send_sample(16'sh2000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    wait_drained();
    reg_write(REG_ACTIVE_SECTIONS, 64'd5);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0100, 1'b0);

    // random phases: new setting each phase, mostly stable sections with random samples
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      if (ph == 0) begin
        reg_write(REG_ACTIVE_SECTIONS, 64'd7);
      end else if (ph == 1) begin
        reg_write(REG_ACTIVE_SECTIONS, {32'($urandom), 29'($urandom), 3'd0});
      end else begin
        reg_write(REG_ACTIVE_SECTIONS,
                  {32'($urandom), 29'($urandom), 3'($urandom_range(0, 7))});
      end
      for (int r = 0; r < MAX_SECTIONS_DEF; r++) begin
        if (ph == 0 || $urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 3) == 0) begin
            reg_write(REG_COEF_BASE + r, {32'($urandom), 32'($urandom)});
          end else begin
            reg_write(REG_COEF_BASE + r, {10'($urandom), stable_section()});
          end
        end
      end
      no_gaps    = (ph % 3 == 2);
      burst_left = $urandom_range(1, 20);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 9))
          6, 7:    s = SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
          8:       s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          9:       s = '0;
          default: s = SAMPLE_W'($urandom);
        endcase
        clr = ($urandom_range(0, 24) == 0);
        send_sample(s, clr);
        if (ph == 4 && i == PHASE_ITEMS / 2) begin
          // hold the sender off until the pipeline is empty mid-phase
          wait_drained();
        end else begin
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = no_gaps ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
              in_valid <= 1'b0;
              repeat (gap) @(negedge clk);
            end
          end
        end
      end
    end

    wait_drained();
    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
